>>> hw/rtl/heightmap_normal_generator_assert.svh
// Assertion macros shared by the heightmap normal generator RTL.
`ifndef HEIGHTMAP_NORMAL_GENERATOR_ASSERT_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked on the local clk and disabled during rst_n.
`define HNG_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the local clk and disabled during rst_n.
`define HNG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hng_pkg.sv
// Shared constants and types of the heightmap normal generator.
`default_nettype none
package hng_pkg;

  localparam int MAX_CELLS  = 256;
  localparam int COL_W      = 8;
  localparam int GRID_W     = 9;
  localparam int HGT_W      = 15;
  localparam int DIFF_W     = 16;
  localparam int RAM_DEPTH  = 2 * MAX_CELLS;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);

  localparam logic [GRID_W-1:0] GRID_RESET = 9'd64;
  localparam logic [GRID_W-1:0] GRID_MIN   = 9'd2;
  localparam logic [GRID_W-1:0] GRID_MAX   = 9'(MAX_CELLS);

  // Height offset: heights are (r*g*b*5 >> 12) - 10240.
  localparam logic signed [DIFF_W-1:0] HGT_OFFSET = 16'sd10240;

  // Square of the fixed y component 2.0 in 1/256 units.
  localparam logic [29:0] Y_SQ = 30'd262144;

  localparam int DIV_STEPS  = 30;
  localparam int SQRT_STEPS = 15;

  typedef logic signed [HGT_W-1:0]  height_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic [14:0]        ny;
    logic signed [15:0] nz;
  } norm_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/hng_stream_if.sv
// Valid/ready stream interfaces for pixels in and normals out.
`default_nettype none
interface hng_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface hng_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         row;
  logic [7:0]         col;
  logic signed [15:0] normal_x;
  logic [14:0]        normal_y;
  logic signed [15:0] normal_z;
  logic               last;

  modport source (output valid, row, col, normal_x, normal_y, normal_z, last, input ready);
  modport sink (input valid, row, col, normal_x, normal_y, normal_z, last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/hng_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module hng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/hng_norm.sv
// Iterative normalizer: exact rounded Q1.14 components of (dx, 512, dz).
`default_nettype none
module hng_norm
  import hng_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire diff_t dx,
  input  wire diff_t dz,
  output logic       busy,
  output logic       done,
  output norm_res_t  res
);

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SQ   = 3'd1;
  localparam logic [2:0] N_SUM  = 3'd2;
  localparam logic [2:0] N_DIV  = 3'd3;
  localparam logic [2:0] N_SQRT = 3'd4;
  localparam logic [2:0] N_DONE = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  cnt_r;
  diff_t       dx_r, dz_r;
  logic        sx_r, sz_r;
  logic [28:0] sqx_r, sqz_r;
  logic [29:0] l2_r;
  logic [29:0] one_r;
  // Lane a holds the remainder, then the radicand; lane b the quotient, then the root.
  logic [30:0] la_r [3];
  logic [29:0] lb_r [3];
  logic [30:0] la_nxt [3];
  logic [29:0] lb_nxt [3];
  logic [30:0] rem2 [3];
  logic [30:0] trial [3];
  logic [14:0] q [3];
  logic [16:0] qsum [3];
  logic signed [31:0] px, pz;

  assign px = dx_r * dx_r;
  assign pz = dz_r * dz_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem2[i]   = {la_r[i][29:0], 1'b0};
      trial[i]  = {1'b0, lb_r[i]} + {1'b0, one_r};
      la_nxt[i] = la_r[i];
      lb_nxt[i] = lb_r[i];
      if (state_r == N_DIV) begin
        if (rem2[i] >= {1'b0, l2_r}) begin
          la_nxt[i] = rem2[i] - {1'b0, l2_r};
          lb_nxt[i] = {lb_r[i][28:0], 1'b1};
        end else begin
          la_nxt[i] = rem2[i];
          lb_nxt[i] = {lb_r[i][28:0], 1'b0};
        end
      end else if (state_r == N_SQRT) begin
        if (la_r[i] >= trial[i]) begin
          la_nxt[i] = la_r[i] - trial[i];
          lb_nxt[i] = (lb_r[i] >> 1) + one_r;
        end else begin
          lb_nxt[i] = lb_r[i] >> 1;
        end
      end
      // The root s gives q as the largest q with 2q-1 <= s.
      qsum[i] = {1'b0, lb_r[i][15:0]} + 17'd1;
      q[i]    = qsum[i][15:1];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      N_IDLE, N_DONE: begin
        if (start) state_nxt = N_SQ;
      end
      N_SQ:  state_nxt = N_SUM;
      N_SUM: state_nxt = N_DIV;
      N_DIV: begin
        if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = N_SQRT;
      end
      N_SQRT: begin
        if (cnt_r == 5'(SQRT_STEPS - 1)) state_nxt = N_DONE;
      end
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE, N_DONE: begin
        if (start) begin
          dx_r <= dx;
          dz_r <= dz;
          sx_r <= dx[15];
          sz_r <= dz[15];
        end
      end
      N_SQ: begin
        sqx_r <= px[28:0];
        sqz_r <= pz[28:0];
      end
      N_SUM: begin
        l2_r     <= {1'b0, sqx_r} + {1'b0, sqz_r} + Y_SQ;
        la_r[0]  <= {2'b00, sqx_r};
        la_r[1]  <= {1'b0, Y_SQ};
        la_r[2]  <= {2'b00, sqz_r};
        lb_r[0]  <= '0;
        lb_r[1]  <= '0;
        lb_r[2]  <= '0;
        cnt_r    <= '0;
      end
      N_DIV: begin
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          // The quotient becomes the radicand of the square root.
          for (int i = 0; i < 3; i++) begin
            la_r[i] <= {1'b0, lb_nxt[i]};
            lb_r[i] <= '0;
          end
          one_r <= 30'h1000_0000;
          cnt_r <= '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            la_r[i] <= la_nxt[i];
            lb_r[i] <= lb_nxt[i];
          end
          cnt_r <= cnt_r + 5'd1;
        end
      end
      N_SQRT: begin
        for (int i = 0; i < 3; i++) begin
          la_r[i] <= la_nxt[i];
          lb_r[i] <= lb_nxt[i];
        end
        one_r <= one_r >> 2;
        cnt_r <= cnt_r + 5'd1;
      end
      default: begin
      end
    endcase
  end

  assign busy   = (state_r != N_IDLE) && (state_r != N_DONE);
  assign done   = (state_r == N_DONE);
  assign res.nx = sx_r ? (16'sd0 - $signed({1'b0, q[0]})) : $signed({1'b0, q[0]});
  assign res.ny = q[1];
  assign res.nz = sz_r ? (16'sd0 - $signed({1'b0, q[2]})) : $signed({1'b0, q[2]});

endmodule
`default_nettype wire

>>> hw/rtl/heightmap_normal_generator.sv
// Heightmap normal generator: RGB pixel stream in, normalized surface normals out.
//
// Pixels arrive row-major for a square grid of grid_cells points (clamped to
// 2..256; a write also restarts the image). Each pixel becomes a height, and
// the normal of grid point (i,j) is the normalized vector (left-right, 2,
// down-up) from central differences, with points outside the grid at height 0.
// Output runs one row behind the input and the last row drains as it arrives,
// so a pixel yields zero to three normals. Two rows of heights live in a
// single-port RAM. After a pixel is accepted, it goes through the height
// products (three steps), six RAM reads and one write. Each of the three
// result slots is then skipped when empty; when used, it starts the shared
// normalizer (square, sum, 30-step divide and 15-step square root, three
// lanes at once) and then loads the output register, waiting while a
// stalled sink holds it. The input is ready again once the slot scan closes,
// so a new pixel is taken only after all work on the pixel before it is done.
`default_nettype none
`include "heightmap_normal_generator_assert.svh"
module heightmap_normal_generator
  import hng_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  hng_in_if.sink                 in_ch,
  hng_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [GRID_W-1:0] cfg_wdata
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;
  localparam logic [3:0] ST_MUL2 = 4'd2;
  localparam logic [3:0] ST_HGT  = 4'd3;
  localparam logic [3:0] ST_RD   = 4'd4;
  localparam logic [3:0] ST_WR   = 4'd5;
  localparam logic [3:0] ST_SEL  = 4'd6;
  localparam logic [3:0] ST_WAIT = 4'd7;

  // Neighbor read slots.
  localparam logic [2:0] RD_LEFT  = 3'd0;
  localparam logic [2:0] RD_DOWN  = 3'd1;
  localparam logic [2:0] RD_UP    = 3'd2;
  localparam logic [2:0] RD_DOWN2 = 3'd3;
  localparam logic [2:0] RD_LEFT3 = 3'd4;
  localparam logic [2:0] RD_DOWN3 = 3'd5;
  localparam logic [2:0] RD_END   = 3'd6;

  // Result slots of one pixel.
  localparam logic [1:0] K_ABOVE = 2'd0;
  localparam logic [1:0] K_PREV  = 2'd1;
  localparam logic [1:0] K_CORNER = 2'd2;
  localparam logic [1:0] K_END   = 2'd3;

  logic [3:0]        state_r, state_nxt;
  logic [GRID_W-1:0] grid_r;
  logic [GRID_W-1:0] n_eff;
  logic [COL_W-1:0]  n_m1;
  logic [COL_W-1:0]  row_cnt_r, col_cnt_r;
  logic [COL_W-1:0]  r_eff, c_eff;
  logic [COL_W-1:0]  pr_r, pc_r;
  logic [7:0]        red_r, green_r, blue_r;
  logic [15:0]       rg_r;
  logic [23:0]       prod_r;
  logic [26:0]       prod5;
  diff_t             hwide;
  height_t           h_r;
  logic [2:0]        rd_cnt_r;
  height_t           nb_r [6];
  logic [1:0]        k_r;
  logic              in_acc;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_addr;
  height_t           ram_rdata;
  logic              par;

  logic              job_valid;
  diff_t             job_dx, job_dz;
  logic [COL_W-1:0]  job_row, job_col;
  logic              job_last;
  logic [COL_W-1:0]  hold_row_r, hold_col_r;
  logic              hold_last_r;

  logic              norm_start, norm_busy, norm_done;
  norm_res_t         norm_res;

  logic              out_valid_r;
  logic [7:0]        out_row_r, out_col_r;
  logic              out_last_r;
  norm_res_t         out_res_r;
  logic              out_load;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    n_eff = grid_r;
    if (grid_r < GRID_MIN) n_eff = GRID_MIN;
    if (grid_r > GRID_MAX) n_eff = GRID_MAX;
  end
  assign n_m1 = 8'(n_eff - 9'd1);

  always_comb begin
    r_eff = row_cnt_r;
    c_eff = col_cnt_r;
    if (({1'b0, row_cnt_r} >= n_eff) || ({1'b0, col_cnt_r} >= n_eff)) begin
      r_eff = '0;
      c_eff = '0;
    end
  end

  // Height = ((r*g*b*10240) >> 23) - 10240, and 10240 / 2^23 = 5 / 2^12.
  assign prod5 = {prod_r, 2'b00} + {3'b000, prod_r};
  assign hwide = $signed({1'b0, prod5[26:12]}) - HGT_OFFSET;

  assign par = pr_r[0];

  always_comb begin
    ram_addr = {par, pc_r};
    case (rd_cnt_r)
      RD_LEFT:  ram_addr = {par, pc_r};
      RD_DOWN:  ram_addr = {~par, pc_r - 8'd1};
      RD_UP:    ram_addr = {~par, pc_r + 8'd1};
      RD_DOWN2: ram_addr = {par, pc_r - 8'd2};
      RD_LEFT3: ram_addr = {~par, pc_r};
      RD_DOWN3: ram_addr = {par, pc_r - 8'd1};
      default:  ram_addr = {par, pc_r};
    endcase
    if (state_r == ST_WR) ram_addr = {par, pc_r};
  end
  assign ram_we = (state_r == ST_WR);

  hng_ram #(
    .WIDTH(HGT_W),
    .DEPTH(RAM_DEPTH)
  ) u_row_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(h_r),
    .rdata(ram_rdata)
  );

  // Pick the next normal of this pixel; neighbors off the grid count as zero.
  always_comb begin
    height_t left1, down1, up1, down2;
    left1     = (pr_r >= 8'd2) ? nb_r[RD_LEFT] : '0;
    down1     = (pc_r != 8'd0) ? nb_r[RD_DOWN] : '0;
    up1       = (pc_r != n_m1) ? nb_r[RD_UP] : '0;
    down2     = (pc_r >= 8'd2) ? nb_r[RD_DOWN2] : '0;
    job_valid = 1'b0;
    job_dx    = '0;
    job_dz    = '0;
    job_row   = pr_r;
    job_col   = pc_r;
    job_last  = 1'b0;
    case (k_r)
      K_ABOVE: begin
        job_valid = (pr_r != 8'd0);
        job_row   = pr_r - 8'd1;
        job_dx    = diff_t'(left1) - diff_t'(h_r);
        job_dz    = diff_t'(down1) - diff_t'(up1);
      end
      K_PREV: begin
        job_valid = (pr_r == n_m1) && (pc_r != 8'd0);
        job_col   = pc_r - 8'd1;
        job_dx    = diff_t'(nb_r[RD_DOWN]);
        job_dz    = diff_t'(down2) - diff_t'(h_r);
      end
      K_CORNER: begin
        job_valid = (pr_r == n_m1) && (pc_r == n_m1);
        job_dx    = diff_t'(nb_r[RD_LEFT3]);
        job_dz    = diff_t'(nb_r[RD_DOWN3]);
        job_last  = 1'b1;
      end
      default: job_valid = 1'b0;
    endcase
  end

  assign norm_start = (state_r == ST_SEL) && (k_r != K_END) && job_valid;
  assign out_load   = (state_r == ST_WAIT) && norm_done && (!out_valid_r || out_ch.ready);

  hng_norm u_norm (
    .clk  (clk),
    .rst_n(rst_n),
    .start(norm_start),
    .dx   (job_dx),
    .dz   (job_dz),
    .busy (norm_busy),
    .done (norm_done),
    .res  (norm_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_HGT;
      ST_HGT:  state_nxt = ST_RD;
      ST_RD: begin
        if (rd_cnt_r == RD_END) state_nxt = ST_WR;
      end
      ST_WR: state_nxt = ST_SEL;
      ST_SEL: begin
        if (k_r == K_END) state_nxt = ST_IDLE;
        else if (job_valid) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_load) state_nxt = ST_SEL;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      grid_r      <= GRID_RESET;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      rd_cnt_r    <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        grid_r    <= cfg_wdata;
        row_cnt_r <= '0;
        col_cnt_r <= '0;
      end else if (in_acc) begin
        if (c_eff == n_m1) begin
          col_cnt_r <= '0;
          row_cnt_r <= (r_eff == n_m1) ? 8'd0 : r_eff + 8'd1;
        end else begin
          col_cnt_r <= c_eff + 8'd1;
          row_cnt_r <= r_eff;
        end
      end
      if (state_r == ST_HGT) rd_cnt_r <= '0;
      else if (state_r == ST_RD) rd_cnt_r <= rd_cnt_r + 3'd1;
      if (state_r == ST_WR) k_r <= K_ABOVE;
      else if (state_r == ST_SEL && k_r != K_END && !job_valid) k_r <= k_r + 2'd1;
      else if (out_load) k_r <= k_r + 2'd1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      red_r   <= in_ch.red;
      green_r <= in_ch.green;
      blue_r  <= in_ch.blue;
      pr_r    <= r_eff;
      pc_r    <= c_eff;
    end
    if (state_r == ST_MUL1) rg_r <= red_r * green_r;
    if (state_r == ST_MUL2) prod_r <= rg_r * blue_r;
    if (state_r == ST_HGT) h_r <= hwide[HGT_W-1:0];
    if (state_r == ST_RD && rd_cnt_r != RD_LEFT) nb_r[rd_cnt_r - 3'd1] <= ram_rdata;
    if (norm_start) begin
      hold_row_r  <= job_row;
      hold_col_r  <= job_col;
      hold_last_r <= job_last;
    end
    if (out_load) begin
      out_row_r  <= hold_row_r;
      out_col_r  <= hold_col_r;
      out_last_r <= hold_last_r;
      out_res_r  <= norm_res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.row      = out_row_r;
  assign out_ch.col      = out_col_r;
  assign out_ch.normal_x = out_res_r.nx;
  assign out_ch.normal_y = out_res_r.ny;
  assign out_ch.normal_z = out_res_r.nz;
  assign out_ch.last     = out_last_r;

  `HNG_ASSERT_NEXT(a_accept_starts_work, in_acc, state_r == ST_MUL1, "pixel did not start")
  `HNG_ASSERT_NEXT(a_norm_restarts, norm_start, norm_busy && !norm_done, "start ignored")
  `HNG_ASSERT_IMPLIES(a_last_on_corner, out_valid_r && out_last_r, out_row_r == n_m1 && out_col_r == n_m1, "bad last")

endmodule
`default_nettype wire

>>> bench/hng_tb_if.sv
`timescale 1ns / 1ps
// Testbench constants: the cycle limit of a run.
package hng_tb_pkg;
  localparam int TB_TIMEOUT = 2000000;
endpackage

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Testbench of the heightmap normal generator: directed and random pixel images checked against a predictor.
module testbench;
  import hng_pkg::*;
  import hng_tb_pkg::*;

  typedef struct packed {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] nx;
    logic [14:0] ny;
    logic [15:0] nz;
    logic        last;
  } normal_t;

  class normal_scoreboard;
    int unsigned cells;
    int          heights[2][MAX_CELLS];
    int unsigned next_row;
    int unsigned next_col;
    normal_t     pending[$];
    int          errors;

    function void set_cells(int unsigned value);
      cells = value;
      next_row = 0;
      next_col = 0;
    endfunction

    function int unsigned side();
      if (cells < 2) return 2;
      if (cells > MAX_CELLS) return MAX_CELLS;
      return cells;
    endfunction

    // Largest q with (2q-1)^2 * l2 <= (32768*mag)^2: rounding with ties away.
    function int unsigned unit_mag(longint unsigned mag, longint unsigned l2);
      longint unsigned rhs, t;
      int unsigned lo, hi, mid;
      rhs = (32768 * mag) * (32768 * mag);
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        t = 2 * mid - 1;
        if (t * t * l2 <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function logic [15:0] signed_unit(int c, longint unsigned l2);
      int unsigned q;
      q = unit_mag(c < 0 ? -c : c, l2);
      return c < 0 ? 16'(17'h10000 - q) : 16'(q);
    endfunction

    function void push_normal(int unsigned r, int unsigned c, int dx, int dz, bit last);
      normal_t e;
      longint unsigned l2;
      l2 = longint'(dx) * dx + longint'(dz) * dz + 262144;
      e.row = 8'(r);
      e.col = 8'(c);
      e.nx = signed_unit(dx, l2);
      e.ny = 15'(unit_mag(512, l2));
      e.nz = signed_unit(dz, l2);
      e.last = last;
      pending = {pending, e};
    endfunction

    function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      int unsigned n, r, c, i, j;
      int h, left, down, up;
      n = side();
      r = next_row;
      c = next_col;
      h = int'((longint'(red) * green * blue * 10240) >>> 23) - 10240;
      if (r >= n || c >= n) begin
        r = 0;
        c = 0;
      end
      if (r >= 1) begin
        i = r - 1;
        left = i > 0 ? heights[(i - 1) & 1][c] : 0;
        down = c > 0 ? heights[i & 1][c - 1] : 0;
        up = c < n - 1 ? heights[i & 1][c + 1] : 0;
        push_normal(i, c, left - h, down - up, 0);
      end
      heights[r & 1][c] = h;
      if (r == n - 1) begin
        if (c >= 1) begin
          j = c - 1;
          left = heights[(r - 1) & 1][j];
          down = j > 0 ? heights[r & 1][j - 1] : 0;
          push_normal(r, j, left, down - h, 0);
        end
        if (c == n - 1)
          push_normal(r, c, heights[(r - 1) & 1][c], heights[r & 1][c - 1], 1);
      end
      c++;
      if (c >= n) begin
        c = 0;
        r++;
        if (r >= n) r = 0;
      end
      next_row = r;
      next_col = c;
    endfunction

    function void check_normal(normal_t got);
      normal_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected normal (%0d,%0d)", got.row, got.col);
        return;
      end
      e = pending.pop_front();
      if (got != e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %p got %p", e, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [GRID_W-1:0] cfg_wdata = '0;
  hng_in_if in_ch();
  hng_out_if out_ch();
  normal_scoreboard board;
  int unsigned cycles = 0;
  int unsigned pixels_sent = 0;
  bit stall_mode = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  heightmap_normal_generator i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Output side: sample at the edge, decide the next ready from a stall pattern in stall mode.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_normal('{out_ch.row, out_ch.col, out_ch.normal_x, out_ch.normal_y,
                           out_ch.normal_z, out_ch.last});
    if (!rst_n) out_ch.ready <= 0;
    else if (stall_mode) out_ch.ready <= (cycles % 13) < 5 || $urandom_range(0, 3) == 0;
    else out_ch.ready <= 1;
    if (cycles >= TB_TIMEOUT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    in_ch.valid <= 1;
    in_ch.red <= red;
    in_ch.green <= green;
    in_ch.blue <= blue;
    do @(posedge clk); while (!in_ch.ready);
    board.note_pixel(red, green, blue);
    pixels_sent++;
  endtask

  task automatic random_pixel();
    case ($urandom_range(0, 5))
      0: send_pixel(8'hff, 8'hff, 8'hff);
      1: send_pixel(8'h00, 8'($urandom), 8'($urandom));
      default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic pause_gap();
    int unsigned gap;
    gap = $urandom_range(0, 4) == 0 ? $urandom_range(1, 12) : 0;
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cells(logic [GRID_W-1:0] value);
    drain();
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    board.set_cells(value);
  endtask

  task automatic send_image(int unsigned count);
    int unsigned burst;
    burst = 0;
    for (int unsigned k = 0; k < count; k++) begin
      if (burst == 0) begin
        pause_gap();
        burst = $urandom_range(1, 20);
      end
      random_pixel();
      burst--;
    end
  endtask

  initial begin
    int unsigned n;
    board = new();
    board.set_cells(64);
    in_ch.valid <= 0;
    in_ch.red <= 0;
    in_ch.green <= 0;
    in_ch.blue <= 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: smallest grid with extreme pixels, then a below-minimum size.
    write_cells(9'd2);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'hff, 8'h01, 8'hff);
    write_cells(9'd0);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hfe);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    write_cells(9'd1);
    for (int k = 0; k < 4; k++) send_pixel(8'haa, 8'h55, 8'hff);
    // Mid-image restart: a write after part of an image.
    write_cells(9'd3);
    for (int k = 0; k < 5; k++) send_pixel(8'($urandom), 8'hff, 8'hff);
    write_cells(9'd3);
    for (int k = 0; k < 9; k++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    stall_mode = 1;
    // Random images of small sizes, with the stream running across images.
    while (pixels_sent < 130) begin
      n = $urandom_range(2, 7);
      write_cells(9'(n));
      send_image(n * n * $urandom_range(1, 2));
    end
    // A size above the maximum: the first row of a 256 grid and the start of the next.
    write_cells(9'h1ff);
    send_image(260);
    write_cells(9'd64);
    send_image(30);
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/hng_pkg.sv
hw/rtl/hng_stream_if.sv
hw/rtl/hng_ram.sv
hw/rtl/hng_norm.sv
hw/rtl/heightmap_normal_generator.sv
bench/hng_tb_if.sv
bench/testbench.sv
